@@ rtl/priority_voice_allocator_defines.svh @@
// Assertion macros shared by the checker of the voice allocator.
// No dependencies; included by rtl/pva_checker.sv.
`ifndef PRIORITY_VOICE_ALLOCATOR_DEFINES_SVH
`define PRIORITY_VOICE_ALLOCATOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PVA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define PVA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/pva_pkg.sv @@
// Shared constants, types and codes of the priority voice allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package pva_pkg;

    localparam int VOICE_SLOTS   = 32;
    localparam int ID_BITS       = 16;
    localparam int EVENT_BITS    = 8;
    localparam int PRIORITY_BITS = 8;

    localparam int SLOT_BITS  = $clog2(VOICE_SLOTS);
    localparam int COUNT_BITS = $clog2(VOICE_SLOTS + 1);
    // Wide enough for the slot count, the register value and an 8-bit limit.
    localparam int CMP_BITS   = (COUNT_BITS > 8) ? COUNT_BITS : 8;

    localparam int APB_ADDR_BITS = 3;
    localparam int REG_LSB       = 2;

    typedef logic [SLOT_BITS-1:0]                 t_slot;
    typedef logic [COUNT_BITS-1:0]                t_count;
    typedef logic [CMP_BITS-1:0]                  t_cmp;
    typedef logic [ID_BITS-1:0]                   t_id;
    typedef logic [EVENT_BITS-1:0]                t_event;
    typedef logic [PRIORITY_BITS-1:0]             t_prio;
    typedef logic [15:0]                          t_id_port;
    typedef logic [5:0]                           t_active;
    typedef logic [5:0]                           t_max_voices;
    typedef logic [31:0]                          t_apb_data;
    typedef logic [APB_ADDR_BITS-REG_LSB-1:0]     t_reg_idx;

    localparam t_reg_idx    REG_MAX_VOICES   = t_reg_idx'(0);
    localparam t_max_voices MAX_VOICES_RESET = t_max_voices'(32);

    localparam logic CMD_PLAY = 1'b0;
    localparam logic CMD_STOP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_REJECTED  = 2'd1,
        STATUS_EXHAUSTED = 2'd2,
        STATUS_MISSING   = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  scan;
        t_slot addr;
        logic  decide;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ rtl/pva_ctrl.sv @@
// Sequencer of the voice allocator: request intake, slot scan and commit.
// Depends on pva_pkg; drives the command bus of pva_dp.
`default_nettype none

module pva_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    output logic              o_busy,
    output pva_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE
    } t_state;

    t_state          r_state;
    pva_pkg::t_slot  r_addr;
    logic            r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_SCAN;
                        r_addr  <= '0;
                        r_busy  <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (r_addr == pva_pkg::t_slot'(pva_pkg::VOICE_SLOTS - 1)) begin
                        r_state <= ST_LAST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                // The last slot read is still being compared in this state.
                ST_LAST: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == ST_IDLE) && i_start;
        o_cmd.scan   = (r_state == ST_SCAN);
        o_cmd.addr   = r_addr;
        o_cmd.decide = (r_state == ST_DECIDE);
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

@@ rtl/pva_dp.sv @@
// Datapath of the voice allocator: slot memory, valid bits, scan trackers,
// victim choice and the result register. Depends on pva_pkg.
`default_nettype none

module pva_dp (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire pva_pkg::t_dp_cmd      i_cmd_bus,
    input  wire                        i_cmd,
    input  wire [7:0]                  i_event_id,
    input  wire [7:0]                  i_event_priority,
    input  wire [7:0]                  i_max_instances,
    input  wire [15:0]                 i_voice_id,
    input  wire pva_pkg::t_max_voices  i_max_voices,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [15:0]                o_new_voice_id,
    output logic                       o_stolen,
    output logic [15:0]                o_stolen_voice_id,
    output logic [5:0]                 o_active_count
);

    // Slot contents; never cleared, only read behind a valid bit.
    pva_pkg::t_id    mem_voice [pva_pkg::VOICE_SLOTS];
    pva_pkg::t_event mem_event [pva_pkg::VOICE_SLOTS];
    pva_pkg::t_prio  mem_prio  [pva_pkg::VOICE_SLOTS];

    logic [pva_pkg::VOICE_SLOTS-1:0] r_valid;

    // Latched request.
    logic            r_req_stop;
    pva_pkg::t_event r_req_event;
    pva_pkg::t_prio  r_req_prio;
    logic [7:0]      r_req_lim;
    pva_pkg::t_id    r_req_vid;

    // Registered memory read.
    pva_pkg::t_id    r_rd_voice;
    pva_pkg::t_event r_rd_event;
    pva_pkg::t_prio  r_rd_prio;
    logic            r_rd_valid;
    pva_pkg::t_slot  r_rd_idx;
    logic            r_eval;

    // Scan trackers.
    logic            r_all_found;
    pva_pkg::t_prio  r_all_prio;
    pva_pkg::t_id    r_all_voice;
    pva_pkg::t_slot  r_all_idx;
    logic            r_same_found;
    pva_pkg::t_prio  r_same_prio;
    pva_pkg::t_id    r_same_voice;
    pva_pkg::t_slot  r_same_idx;
    pva_pkg::t_count r_count;
    logic            r_free_found;
    pva_pkg::t_slot  r_free_idx;
    logic            r_match_found;
    pva_pkg::t_slot  r_match_idx;

    pva_pkg::t_id    r_next_id;
    pva_pkg::t_count r_live;

    logic             r_out_valid;
    pva_pkg::t_status r_out_status;
    pva_pkg::t_id     r_out_new_id;
    logic             r_out_stolen;
    pva_pkg::t_id     r_out_stolen_id;
    pva_pkg::t_count  r_out_live;

    // Scan compare signals.
    logic ev_hit;
    logic better_all;
    logic better_same;
    logic id_match;

    // Decision signals.
    pva_pkg::t_cmp    limit;
    logic             at_limit;
    logic             need_steal;
    logic             v_found;
    pva_pkg::t_prio   v_prio;
    pva_pkg::t_id     v_voice;
    pva_pkg::t_slot   v_idx;
    logic             reject;
    logic             exhausted;
    pva_pkg::t_slot   fill_idx;
    logic             clr_en;
    pva_pkg::t_slot   clr_idx;
    logic             wr_en;
    pva_pkg::t_status n_status;
    pva_pkg::t_id     n_new_id;
    logic             n_stolen;
    pva_pkg::t_id     n_stolen_id;
    pva_pkg::t_count  n_live;
    logic [pva_pkg::VOICE_SLOTS-1:0] n_valid;

    always_comb begin
        ev_hit      = r_rd_valid && (r_rd_event == r_req_event);
        better_all  = r_rd_valid && (!r_all_found || (r_rd_prio < r_all_prio) ||
                      ((r_rd_prio == r_all_prio) && (r_rd_voice < r_all_voice)));
        better_same = ev_hit && (!r_same_found || (r_rd_prio < r_same_prio) ||
                      ((r_rd_prio == r_same_prio) && (r_rd_voice < r_same_voice)));
        id_match    = r_rd_valid && (r_req_vid != '0) && (r_rd_voice == r_req_vid);
    end

    always_comb begin
        if (i_max_voices == '0) begin
            limit = pva_pkg::t_cmp'(1);
        end else if (pva_pkg::t_cmp'(i_max_voices) > pva_pkg::t_cmp'(pva_pkg::VOICE_SLOTS)) begin
            limit = pva_pkg::t_cmp'(pva_pkg::VOICE_SLOTS);
        end else begin
            limit = pva_pkg::t_cmp'(i_max_voices);
        end

        at_limit   = pva_pkg::t_cmp'(r_count) >= pva_pkg::t_cmp'(r_req_lim);
        need_steal = (pva_pkg::t_cmp'(r_live) >= limit) || at_limit;
        v_found    = at_limit ? r_same_found : r_all_found;
        v_prio     = at_limit ? r_same_prio  : r_all_prio;
        v_voice    = at_limit ? r_same_voice : r_all_voice;
        v_idx      = at_limit ? r_same_idx   : r_all_idx;
        reject     = need_steal && (!v_found || (v_prio > r_req_prio));
        exhausted  = (r_next_id == '0);

        // The lowest free slot, counting the one that the eviction opens.
        if (need_steal && !(r_free_found && (r_free_idx < v_idx))) begin
            fill_idx = v_idx;
        end else begin
            fill_idx = r_free_idx;
        end

        clr_en      = 1'b0;
        clr_idx     = v_idx;
        wr_en       = 1'b0;
        n_status    = pva_pkg::STATUS_OK;
        n_new_id    = '0;
        n_stolen    = 1'b0;
        n_stolen_id = '0;
        n_live      = r_live;

        if (r_req_stop == pva_pkg::CMD_STOP) begin
            if (r_match_found) begin
                clr_en  = 1'b1;
                clr_idx = r_match_idx;
                n_live  = r_live - 1'b1;
            end else begin
                n_status = pva_pkg::STATUS_MISSING;
            end
        end else if (reject) begin
            n_status = pva_pkg::STATUS_REJECTED;
        end else begin
            if (need_steal) begin
                clr_en      = 1'b1;
                n_stolen    = 1'b1;
                n_stolen_id = v_voice;
            end
            if (exhausted) begin
                n_status = pva_pkg::STATUS_EXHAUSTED;
                n_live   = need_steal ? (r_live - 1'b1) : r_live;
            end else begin
                wr_en    = 1'b1;
                n_new_id = r_next_id;
                n_live   = need_steal ? r_live : (r_live + 1'b1);
            end
        end
    end

    // A fill into the slot just evicted must win over the clear.
    always_comb begin
        n_valid = r_valid;
        if (i_cmd_bus.decide && clr_en) begin
            n_valid[clr_idx] = 1'b0;
        end
        if (i_cmd_bus.decide && wr_en) begin
            n_valid[fill_idx] = 1'b1;
        end
    end

    // Memory read and write ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.scan) begin
            r_rd_voice <= mem_voice[i_cmd_bus.addr];
            r_rd_event <= mem_event[i_cmd_bus.addr];
            r_rd_prio  <= mem_prio[i_cmd_bus.addr];
        end
        if (i_cmd_bus.decide && wr_en) begin
            mem_voice[fill_idx] <= r_next_id;
            mem_event[fill_idx] <= r_req_event;
            mem_prio[fill_idx]  <= r_req_prio;
        end
    end

    // Request and tracker payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load) begin
            r_req_stop  <= i_cmd;
            r_req_event <= pva_pkg::t_event'(i_event_id);
            r_req_prio  <= pva_pkg::t_prio'(i_event_priority);
            r_req_lim   <= i_max_instances;
            r_req_vid   <= pva_pkg::t_id'(i_voice_id);
        end
        if (i_cmd_bus.scan) begin
            r_rd_idx <= i_cmd_bus.addr;
        end
        if (r_eval) begin
            if (better_all) begin
                r_all_prio  <= r_rd_prio;
                r_all_voice <= r_rd_voice;
                r_all_idx   <= r_rd_idx;
            end
            if (better_same) begin
                r_same_prio  <= r_rd_prio;
                r_same_voice <= r_rd_voice;
                r_same_idx   <= r_rd_idx;
            end
            if (!r_rd_valid && !r_free_found) begin
                r_free_idx <= r_rd_idx;
            end
            if (id_match) begin
                r_match_idx <= r_rd_idx;
            end
        end
        if (i_cmd_bus.decide) begin
            r_out_status    <= n_status;
            r_out_new_id    <= n_new_id;
            r_out_stolen    <= n_stolen;
            r_out_stolen_id <= n_stolen_id;
            r_out_live      <= n_live;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_rd_valid    <= 1'b0;
            r_eval        <= 1'b0;
            r_all_found   <= 1'b0;
            r_same_found  <= 1'b0;
            r_count       <= '0;
            r_free_found  <= 1'b0;
            r_match_found <= 1'b0;
            r_next_id     <= pva_pkg::t_id'(1);
            r_live        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_eval      <= i_cmd_bus.scan;
            r_out_valid <= i_cmd_bus.decide;
            r_valid     <= n_valid;
            if (i_cmd_bus.scan) begin
                r_rd_valid <= r_valid[i_cmd_bus.addr];
            end
            if (i_cmd_bus.load) begin
                r_all_found   <= 1'b0;
                r_same_found  <= 1'b0;
                r_count       <= '0;
                r_free_found  <= 1'b0;
                r_match_found <= 1'b0;
            end else if (r_eval) begin
                if (better_all) begin
                    r_all_found <= 1'b1;
                end
                if (better_same) begin
                    r_same_found <= 1'b1;
                end
                if (ev_hit) begin
                    r_count <= r_count + 1'b1;
                end
                if (!r_rd_valid) begin
                    r_free_found <= 1'b1;
                end
                if (id_match) begin
                    r_match_found <= 1'b1;
                end
            end
            if (i_cmd_bus.decide) begin
                r_live <= n_live;
                if (wr_en) begin
                    r_next_id <= r_next_id + 1'b1;
                end
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_new_voice_id    = pva_pkg::t_id_port'(r_out_new_id);
    assign o_stolen          = r_out_stolen;
    assign o_stolen_voice_id = pva_pkg::t_id_port'(r_out_stolen_id);
    assign o_active_count    = pva_pkg::t_active'(r_out_live);

endmodule

`default_nettype wire

@@ rtl/priority_voice_allocator.sv @@
// Priority voice allocator: a request is accepted when start is high and busy low;
// busy then stays high through the commit state and o_valid pulses as busy falls.
// Busy covers the scan of the voice slot memory, one slot per cycle, then a compare
// state and a commit state; one request is in flight at a time.
// Synchronous active-low reset clears the valid bits and counters, sets the next
// voice id to 1 and max_voices to 32; slot contents are not cleared.
`default_nettype none

module priority_voice_allocator (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire                                  i_cmd,
    input  wire  [7:0]                           i_event_id,
    input  wire  [7:0]                           i_event_priority,
    input  wire  [7:0]                           i_max_instances,
    input  wire  [15:0]                          i_voice_id,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic [15:0]                          o_new_voice_id,
    output logic                                 o_stolen,
    output logic [15:0]                          o_stolen_voice_id,
    output logic [5:0]                           o_active_count,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [pva_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire  [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    pva_pkg::t_max_voices r_max_voices;
    pva_pkg::t_dp_cmd     cmd_bus;
    pva_pkg::t_reg_idx    reg_idx;

    assign reg_idx = paddr[pva_pkg::APB_ADDR_BITS-1:pva_pkg::REG_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_voices <= pva_pkg::MAX_VOICES_RESET;
        end else if (psel && penable && pwrite && (reg_idx == pva_pkg::REG_MAX_VOICES)) begin
            r_max_voices <= pva_pkg::t_max_voices'(pwdata);
        end
    end

    always_comb begin
        if (reg_idx == pva_pkg::REG_MAX_VOICES) begin
            prdata = pva_pkg::t_apb_data'(r_max_voices);
        end else begin
            prdata = '0;
        end
    end

    assign pready = 1'b1;

    pva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd_bus)
    );

    pva_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_bus         (cmd_bus),
        .i_cmd             (i_cmd),
        .i_event_id        (i_event_id),
        .i_event_priority  (i_event_priority),
        .i_max_instances   (i_max_instances),
        .i_voice_id        (i_voice_id),
        .i_max_voices      (r_max_voices),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_new_voice_id    (o_new_voice_id),
        .o_stolen          (o_stolen),
        .o_stolen_voice_id (o_stolen_voice_id),
        .o_active_count    (o_active_count)
    );

endmodule

`default_nettype wire

@@ rtl/pva_checker.sv @@
// Port-level checker of the voice allocator, bound to the top level.
// Depends on pva_pkg and priority_voice_allocator_defines.svh.
`default_nettype none
`include "priority_voice_allocator_defines.svh"

module pva_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_valid,
    input wire [1:0]  o_status,
    input wire [15:0] o_new_voice_id,
    input wire        o_stolen,
    input wire [15:0] o_stolen_voice_id,
    input wire [5:0]  o_active_count
);

    // An accepted request keeps the block busy until its result is out.
    `PVA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")

    // A result only follows a cycle of work.
    `PVA_ASSERT(a_result_after_busy, o_valid |-> $past(busy), "result strobe without a request in work")

    // Only a successful play hands out a voice id.
    `PVA_ASSERT(a_id_on_ok, (o_valid && (o_status != pva_pkg::STATUS_OK)) |-> (o_new_voice_id == 16'd0), "voice id given on a failed request")

    // The live count never exceeds the slot count.
    `PVA_ASSERT(a_count_range, o_valid |-> (o_active_count <= 6'(pva_pkg::VOICE_SLOTS)), "active count beyond slot count")

    // The result strobe is one cycle per request.
    `PVA_ASSERT_ALWAYS(a_single_strobe, (i_rst_n && o_valid) |=> !o_valid, "result strobe held for two cycles")

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (.*);

`default_nettype wire

@@ bench/pva_result_checker.sv @@
// Result checker for the priority voice allocator: predicts each request's result
// from a private copy of the voice table and compares it with what the block reports.
// Depends on rtl/pva_pkg.sv for types, status codes and register indexes.
module pva_result_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire                                i_busy,
    input  wire                                i_cmd,
    input  wire  [7:0]                         i_event_id,
    input  wire  [7:0]                         i_event_priority,
    input  wire  [7:0]                         i_max_instances,
    input  wire  [15:0]                        i_voice_id,
    input  wire                                i_valid,
    input  wire  [1:0]                         i_status,
    input  wire  [15:0]                        i_new_voice_id,
    input  wire                                i_stolen,
    input  wire  [15:0]                        i_stolen_voice_id,
    input  wire  [5:0]                         i_active_count,
    input  wire                                i_psel,
    input  wire                                i_penable,
    input  wire                                i_pwrite,
    input  wire  [pva_pkg::APB_ADDR_BITS-1:0]  i_paddr,
    input  wire  [31:0]                        i_pwdata,
    input  wire                                i_pready,
    output int                                 o_errors,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        pva_pkg::t_status  status;
        pva_pkg::t_id_port new_id;
        logic              stolen;
        pva_pkg::t_id_port stolen_id;
        pva_pkg::t_active  active;
    } t_voice_outcome;

    t_voice_outcome expected_outcomes[$];
    int             mismatches = 0;

    // Private copy of the voice table.
    logic                 slot_live [pva_pkg::VOICE_SLOTS];
    pva_pkg::t_id         slot_voice[pva_pkg::VOICE_SLOTS];
    pva_pkg::t_event      slot_event[pva_pkg::VOICE_SLOTS];
    pva_pkg::t_prio       slot_prio [pva_pkg::VOICE_SLOTS];
    pva_pkg::t_id         next_voice_id;
    int                   live_voices;
    pva_pkg::t_max_voices max_voices_reg;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] voice allocator mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
        end
    endtask

    function automatic int voice_cap();
        if (max_voices_reg < 1) return 1;
        if (max_voices_reg > pva_pkg::VOICE_SLOTS) return pva_pkg::VOICE_SLOTS;
        return int'(max_voices_reg);
    endfunction

    // True when slot a is a better steal candidate than slot b (b < 0 means none yet).
    function automatic logic weaker_voice(int a, int b);
        if (b < 0) return 1'b1;
        if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
        return slot_voice[a] < slot_voice[b];
    endfunction

    function automatic t_voice_outcome stop_voice(pva_pkg::t_id vid);
        t_voice_outcome r;
        r.status    = pva_pkg::STATUS_MISSING;
        r.new_id    = '0;
        r.stolen    = 1'b0;
        r.stolen_id = '0;
        if (vid != '0) begin
            for (int i = 0; i < pva_pkg::VOICE_SLOTS; i++) begin
                if (r.status == pva_pkg::STATUS_MISSING && slot_live[i] &&
                    slot_voice[i] == vid) begin
                    slot_live[i] = 1'b0;
                    live_voices--;
                    r.status = pva_pkg::STATUS_OK;
                end
            end
        end
        r.active = pva_pkg::t_active'(live_voices);
        return r;
    endfunction

    function automatic t_voice_outcome play_voice(pva_pkg::t_event ev, pva_pkg::t_prio pr,
                                                  logic [7:0] lim);
        t_voice_outcome r;
        int   same_count;
        int   pick_all;
        int   pick_same;
        int   victim;
        int   free_slot;
        logic at_limit;
        r.status    = pva_pkg::STATUS_OK;
        r.new_id    = '0;
        r.stolen    = 1'b0;
        r.stolen_id = '0;
        same_count  = 0;
        pick_all    = -1;
        pick_same   = -1;
        free_slot   = -1;
        for (int i = 0; i < pva_pkg::VOICE_SLOTS; i++) begin
            if (slot_live[i]) begin
                if (weaker_voice(i, pick_all)) pick_all = i;
                if (slot_event[i] == ev) begin
                    same_count++;
                    if (weaker_voice(i, pick_same)) pick_same = i;
                end
            end
        end
        // A limit of zero always counts as reached, so only the same event is searched.
        at_limit = same_count >= int'(lim);
        victim   = at_limit ? pick_same : pick_all;
        if (live_voices >= voice_cap() || at_limit) begin
            if (victim < 0 || slot_prio[victim] > pr) begin
                r.status = pva_pkg::STATUS_REJECTED;
                r.active = pva_pkg::t_active'(live_voices);
                return r;
            end
            r.stolen    = 1'b1;
            r.stolen_id = slot_voice[victim];
            slot_live[victim] = 1'b0;
            live_voices--;
        end
        // The eviction above stands even when the id space has run out.
        if (next_voice_id == '0) begin
            r.status = pva_pkg::STATUS_EXHAUSTED;
            r.active = pva_pkg::t_active'(live_voices);
            return r;
        end
        for (int i = pva_pkg::VOICE_SLOTS - 1; i >= 0; i--) begin
            if (!slot_live[i]) free_slot = i;
        end
        if (free_slot < 0) begin
            r.status = pva_pkg::STATUS_REJECTED;
        end else begin
            slot_live[free_slot]  = 1'b1;
            slot_voice[free_slot] = next_voice_id;
            slot_event[free_slot] = ev;
            slot_prio[free_slot]  = pr;
            live_voices++;
            r.new_id      = next_voice_id;
            next_voice_id = next_voice_id + 1'b1;
        end
        r.active = pva_pkg::t_active'(live_voices);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_voice_outcome want;
        t_voice_outcome fresh;
        if (!i_rst_n) begin
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            next_voice_id  = pva_pkg::t_id'(1);
            live_voices    = 0;
            max_voices_reg = pva_pkg::MAX_VOICES_RESET;
            expected_outcomes.delete();
        end else begin
            if (i_valid) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result reported with no request outstanding");
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("new_voice_id", want.new_id, i_new_voice_id);
                    check_field("stolen", want.stolen, i_stolen);
                    check_field("stolen_voice_id", want.stolen_id, i_stolen_voice_id);
                    check_field("active_count", want.active, i_active_count);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[pva_pkg::APB_ADDR_BITS-1:pva_pkg::REG_LSB] ==
                pva_pkg::REG_MAX_VOICES) begin
                max_voices_reg = pva_pkg::t_max_voices'(i_pwdata);
            end
            if (i_start && !i_busy) begin
                if (i_cmd == pva_pkg::CMD_STOP) begin
                    fresh = stop_voice(i_voice_id);
                end else begin
                    fresh = play_voice(i_event_id, i_event_priority, i_max_instances);
                end
                expected_outcomes.insert(expected_outcomes.size(), fresh);
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_outcomes.size();
    end

endmodule

@@ bench/priority_voice_allocator_test.sv @@
// Top of the priority voice allocator testbench: clock, reset, request and register
// stimulus, and the verdict. Depends on rtl/pva_pkg.sv, the block and pva_result_checker.
module priority_voice_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                               i_clk            = 1'b0;
    logic                               i_rst_n          = 1'b0;
    logic                               start            = 1'b0;
    logic                               i_cmd            = pva_pkg::CMD_PLAY;
    logic [7:0]                         i_event_id       = '0;
    logic [7:0]                         i_event_priority = '0;
    logic [7:0]                         i_max_instances  = '0;
    logic [15:0]                        i_voice_id       = '0;
    logic                               psel             = 1'b0;
    logic                               penable          = 1'b0;
    logic                               pwrite           = 1'b0;
    logic [pva_pkg::APB_ADDR_BITS-1:0]  paddr            = '0;
    logic [31:0]                        pwdata           = '0;
    wire                                busy;
    wire                                o_valid;
    wire  [1:0]                         o_status;
    wire  [15:0]                        o_new_voice_id;
    wire                                o_stolen;
    wire  [15:0]                        o_stolen_voice_id;
    wire  [5:0]                         o_active_count;
    wire  [31:0]                        prdata;
    wire                                pready;

    int           errors;
    int           pending;
    bit           gaps_on       = 1'b0;
    int           plays_sent    = 0;
    int           stops_sent    = 0;
    int           settings_used = 0;
    int           steals        = 0;
    bit           ids_exhausted = 1'b0;
    pva_pkg::t_id recent_ids[16];
    logic [3:0]   recent_wr     = '0;
    int           recent_fill   = 0;

    int unsigned phase_caps[9] = '{32, 4, 1, 63, 0, 17, 40, 2, 32};

    priority_voice_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_event_id        (i_event_id),
        .i_event_priority  (i_event_priority),
        .i_max_instances   (i_max_instances),
        .i_voice_id        (i_voice_id),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_new_voice_id    (o_new_voice_id),
        .o_stolen          (o_stolen),
        .o_stolen_voice_id (o_stolen_voice_id),
        .o_active_count    (o_active_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    pva_result_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_cmd             (i_cmd),
        .i_event_id        (i_event_id),
        .i_event_priority  (i_event_priority),
        .i_max_instances   (i_max_instances),
        .i_voice_id        (i_voice_id),
        .i_valid           (o_valid),
        .i_status          (o_status),
        .i_new_voice_id    (o_new_voice_id),
        .i_stolen          (o_stolen),
        .i_stolen_voice_id (o_stolen_voice_id),
        .i_active_count    (o_active_count),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_errors          (errors),
        .o_pending         (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("priority_voice_allocator_test failed");
        $finish;
    end

    // Count steals and id exhaustion, and remember recently granted ids so that stop requests can hit live voices.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (o_status == pva_pkg::STATUS_EXHAUSTED) ids_exhausted <= 1'b1;
            if (o_stolen) steals <= steals + 1;
            if (o_new_voice_id != '0) begin
                recent_ids[recent_wr] <= o_new_voice_id;
                recent_wr             <= recent_wr + 1'b1;
                recent_fill           <= (recent_fill < 16) ? recent_fill + 1 : 16;
            end
        end
    end

    task automatic send_request(logic cmd, pva_pkg::t_event ev, pva_pkg::t_prio pr,
                                logic [7:0] lim, pva_pkg::t_id vid);
        int gap;
        if (gaps_on && $urandom_range(99) < 35) begin
            gap = $urandom_range(1, 40);
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_cmd            <= cmd;
        i_event_id       <= ev;
        i_event_priority <= pr;
        i_max_instances  <= lim;
        i_voice_id       <= vid;
        do @(posedge i_clk); while (busy);
        start <= 1'b0;
        @(posedge i_clk);
        if (cmd == pva_pkg::CMD_STOP) stops_sent++;
        else plays_sent++;
    endtask

    task automatic play(pva_pkg::t_event ev, pva_pkg::t_prio pr, logic [7:0] lim);
        send_request(pva_pkg::CMD_PLAY, ev, pr, lim, pva_pkg::t_id'($urandom));
    endtask

    task automatic stop(pva_pkg::t_id vid);
        send_request(pva_pkg::CMD_STOP, pva_pkg::t_event'($urandom),
                     pva_pkg::t_prio'($urandom), 8'($urandom), vid);
    endtask

    task automatic wait_for_drain();
        while (pending != 0) @(posedge i_clk);
    endtask

    // Registers change only with the block idle; upper data bits carry junk.
    task automatic write_max_voices(int unsigned value);
        wait_for_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {pva_pkg::REG_MAX_VOICES, {pva_pkg::REG_LSB{1'b0}}};
        pwdata  <= ($urandom & 32'hFFFF_FFC0) | (value & 32'h3F);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic random_request();
        int              pick;
        int              ev_pick;
        pva_pkg::t_event ev;
        pva_pkg::t_prio  pr;
        logic [7:0]      lim;
        pva_pkg::t_id    known;
        pick    = $urandom_range(99);
        ev_pick = $urandom_range(99);
        known   = (recent_fill > 0) ? recent_ids[$urandom_range(recent_fill - 1)] :
                  pva_pkg::t_id'(1);
        if (pick < 55) begin
            // Events from a small pool collide often, which drives the per-event limit.
            ev = (ev_pick < 70) ? pva_pkg::t_event'($urandom_range(5)) :
                 pva_pkg::t_event'($urandom);
            case ($urandom_range(3))
                0: pr = 8'd0;
                1: pr = 8'd255;
                2: pr = 8'd128;
                default: pr = pva_pkg::t_prio'($urandom);
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3: lim = 8'($urandom_range(3));
                4, 5, 6: lim = 8'hFF;
                default: lim = 8'($urandom);
            endcase
            play(ev, pr, lim);
        end else if (pick < 85) begin
            stop(known);
        end else if (pick < 88) begin
            stop('0);
        end else if (pick < 94) begin
            stop(known + pva_pkg::t_id'($urandom_range(1, 3)));
        end else begin
            stop(pva_pkg::t_id'($urandom));
        end
        if ($urandom_range(99) < 2) wait_for_drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: missing ids, zero instance limit, limit steals, voice cap reached, zero voice cap, ties.
        stop('0);
        stop(16'hFFFF);
        play(8'd0, 8'd0, 8'd0);
        play(8'd0, 8'd0, 8'hFF);
        play(8'd255, 8'd255, 8'd1);
        play(8'd255, 8'd100, 8'd1);
        play(8'd255, 8'd255, 8'd1);
        play(8'd0, 8'd0, 8'd0);
        stop(16'd4);
        stop(16'd4);
        write_max_voices(2);
        play(8'd1, 8'd10, 8'hFF);
        play(8'd2, 8'd5, 8'hFF);
        play(8'd2, 8'd10, 8'hFF);
        write_max_voices(63);
        play(8'd40, 8'd50, 8'd2);
        play(8'd40, 8'd50, 8'd2);
        play(8'd40, 8'd50, 8'd2);
        play(8'd40, 8'd49, 8'd2);
        write_max_voices(0);
        play(8'd41, 8'd255, 8'hFF);
        play(8'd42, 8'd0, 8'hFF);
        stop(16'hFFFF);

        // Random phases over a range of voice caps; the first one runs without gaps.
        foreach (phase_caps[p]) begin
            write_max_voices(phase_caps[p]);
            gaps_on = (p != 0);
            repeat (80) random_request();
        end

        gaps_on = 1'b1;
        write_max_voices(32);
        repeat (12) random_request();

        wait_for_drain();
        repeat (40) @(posedge i_clk);
        $display("Ran %0d play and %0d stop requests under %0d voice cap settings.",
                 plays_sent, stops_sent, settings_used);
        $display("Voices stolen: %0d; id space ran out: %0d.", steals, ids_exhausted);
        if (errors == 0 && pending == 0) begin
            $display("priority_voice_allocator_test passed");
        end else begin
            $display("priority_voice_allocator_test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pva_pkg.sv
rtl/pva_ctrl.sv
rtl/pva_dp.sv
rtl/priority_voice_allocator.sv
rtl/pva_checker.sv
bench/pva_result_checker.sv
bench/priority_voice_allocator_test.sv
